[rtl/dcc_packet_function_decoder_unit_assert.svh]
// ---------------------------------------------------------------------------
// DCC function decoder assertion macros
// Concurrent checks for the decoder RTL, clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef DCC_PACKET_FUNCTION_DECODER_UNIT_ASSERT_SVH
`define DCC_PACKET_FUNCTION_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define DCCFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCCFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dccfd_pkg.sv]
// ---------------------------------------------------------------------------
// DCC function decoder package
// Shared constants, codes and types of the DCC packet function decoder.
// ---------------------------------------------------------------------------
package dccfd_pkg;

  localparam int MAX_PACKET_BYTES = 6;
  localparam int MAX_PACKET_LIMIT = 8;
  localparam int CNT_W            = $clog2(MAX_PACKET_LIMIT + 1);
  localparam int VIEW_BYTES       = 5;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W           = 14;
  localparam int CONSIST_W        = 7;
  localparam int FUNC_W           = 21;
  localparam int TDATA_OUT_W      = 48;

  localparam logic [7:0] CV_WRITE_MASK   = 8'b1111_1100;
  localparam logic [7:0] CV_WRITE_CODE   = 8'b1110_1100;
  localparam logic [7:0] SPEED128_CODE   = 8'h3F;
  localparam logic [7:0] GROUP2A_CODE    = 8'b1011_0000;
  localparam logic [7:0] GROUP2B_CODE    = 8'b1010_0000;
  localparam logic [7:0] EXPANSION_F13   = 8'b1101_1110;
  localparam logic [7:0] LONG_ADDR_MASK  = 8'b0011_1111;
  localparam logic [7:0] SHORT_ADDR_MASK = 8'b0111_1111;
  localparam logic [7:0] GROUP_SEL_MASK  = 8'b1110_0000;
  localparam logic [7:0] GROUP1_CODE     = 8'b1000_0000;
  localparam logic [7:0] NIBBLE_SEL_MASK = 8'b1111_0000;
  localparam logic [7:0] RESET_CV_BYTE   = 8'd7;
  localparam logic [7:0] RESET_CV_VALUE  = 8'd8;

  localparam logic [ADDR_W-1:0]    OWN_ADDRESS_RESET     = ADDR_W'(3);
  localparam logic [CONSIST_W-1:0] CONSIST_ADDRESS_RESET = '0;
  localparam logic [ADDR_W-1:0]    SERVICE_ADDRESS_RESET = '0;

  typedef enum logic [1:0] {
    REG_OWN_ADDRESS     = 2'd0,
    REG_CONSIST_ADDRESS = 2'd1,
    REG_SERVICE_ADDRESS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0]              count;
    logic [7:0]                    final_byte;
    logic [VIEW_BYTES-1:0][7:0]    bytes;
  } packet_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/dccfd_front.sv]
// ---------------------------------------------------------------------------
// DCC function decoder front end
// Accepts packet bytes, buffers them and hands a finished packet to the queue.
// ---------------------------------------------------------------------------
module dccfd_front
  import dccfd_pkg::*;
#(
  parameter int MaxBytes = MAX_PACKET_BYTES
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic [7:0] s_tdata,   // packet_byte
  input  logic      s_tlast,    // last_byte
  input  q_status_t q_stat,
  output logic      push,
  output packet_t   packet
);

  localparam int IdxW = $clog2(MaxBytes);

  logic [7:0]       store [MaxBytes];
  logic [7:0]       store_next [MaxBytes];
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       last_stored;
  logic             room;
  logic             accept;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign room     = byte_count < CNT_W'(MaxBytes);
  assign push     = accept && s_tlast;

  always_comb begin
    store_next = store;
    if (room) begin
      store_next[byte_count[IdxW-1:0]] = s_tdata;
    end
  end

  always_comb begin
    byte_count_next = byte_count;
    if (accept) begin
      if (s_tlast) begin
        byte_count_next = '0;
      end else if (room) begin
        byte_count_next = byte_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store <= store_next;
    end
    if (accept && room) begin
      last_stored <= s_tdata;
    end
  end

  for (genvar i = 0; i < VIEW_BYTES; i++) begin : g_view
    if (i < MaxBytes) begin : g_in
      assign packet.bytes[i] = store_next[i];
    end else begin : g_out
      assign packet.bytes[i] = '0;
    end
  end

  assign packet.final_byte = room ? s_tdata : last_stored;
  assign packet.count      = room ? byte_count + CNT_W'(1) : byte_count;

endmodule

[rtl/dccfd_queue.sv]
// ---------------------------------------------------------------------------
// DCC function decoder packet queue
// Short queue of finished packets between the front and back ends.
// ---------------------------------------------------------------------------
module dccfd_queue
  import dccfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  packet_t   push_packet,
  input  logic      pop,
  output packet_t   head,
  output q_status_t q_stat
);

  localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

  packet_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [LvlW-1:0]   level;

  assign q_stat.full  = level == LvlW'(QUEUE_DEPTH);
  assign q_stat.empty = level == '0;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + LvlW'(1);
      end else if (pop && !push) begin
        level <= level - LvlW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_packet;
    end
  end

endmodule

[rtl/dccfd_back.sv]
// ---------------------------------------------------------------------------
// DCC function decoder back end
// Decodes one queued packet, updates decoder state and registers the result.
// ---------------------------------------------------------------------------
module dccfd_back
  import dccfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  packet_t                head,
  input  q_status_t              q_stat,
  output logic                   pop,
  input  logic [ADDR_W-1:0]      own_address,
  input  logic [CONSIST_W-1:0]   consist_address,
  input  logic [ADDR_W-1:0]      service_address,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata
);

  logic              s;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        instr;
  logic [7:0]        arg0;
  logic [7:0]        arg1;
  logic [CNT_W-1:0]  s_ext;
  logic              addr_nz;
  logic              cv_hit;
  logic              op_hit;

  logic              direction_reg;
  logic              direction_next;
  logic [FUNC_W-1:0] function_reg;
  logic [FUNC_W-1:0] function_next;
  logic [7:0]        previous_final_byte;

  logic              addressed_next;
  logic              cv_write_next;
  logic              decoder_reset_next;
  logic [8:0]        cv_number_next;
  logic [7:0]        cv_value_next;

  logic              addressed;
  logic              cv_write;
  logic              decoder_reset;
  logic [8:0]        cv_number;
  logic [7:0]        cv_value;

  assign pop = !q_stat.empty && (!m_tvalid || m_tready);

  assign s     = head.bytes[0][7];
  assign s_ext = CNT_W'(s);
  assign addr  = s ? {head.bytes[0][5:0] & LONG_ADDR_MASK[5:0], head.bytes[1]}
                   : {7'b0, head.bytes[0][6:0] & SHORT_ADDR_MASK[6:0]};
  assign instr = s ? head.bytes[2] : head.bytes[1];
  assign arg0  = s ? head.bytes[3] : head.bytes[2];
  assign arg1  = s ? head.bytes[4] : head.bytes[3];

  assign addr_nz = addr != '0;
  assign cv_hit  = addr_nz && (addr == own_address || addr == service_address)
                   && ((instr & CV_WRITE_MASK) == CV_WRITE_CODE);
  assign op_hit  = addr_nz && (addr == own_address || addr == {7'b0, consist_address});

  always_comb begin
    addressed_next     = 1'b0;
    cv_write_next      = 1'b0;
    decoder_reset_next = 1'b0;
    cv_number_next     = '0;
    cv_value_next      = '0;
    direction_next     = direction_reg;
    function_next      = function_reg;
    if (cv_hit) begin
      addressed_next = 1'b1;
      if (head.final_byte == previous_final_byte) begin
        cv_number_next = {1'b0, arg0} + 9'd1;
        cv_value_next  = arg1;
        if (arg0 == RESET_CV_BYTE && arg1 == RESET_CV_VALUE) begin
          decoder_reset_next = 1'b1;
        end else begin
          cv_write_next = 1'b1;
        end
      end
    end else if (op_hit) begin
      addressed_next = 1'b1;
      if (!instr[7]) begin
        if (instr == SPEED128_CODE && head.count == CNT_W'(4) + s_ext) begin
          direction_next = arg0[7];
        end else if (head.count == CNT_W'(3) + s_ext) begin
          direction_next = instr[5];
        end
      end else if ((instr & GROUP_SEL_MASK) == GROUP1_CODE) begin
        function_next[0]   = instr[4];
        function_next[4:1] = instr[3:0];
      end else if ((instr & NIBBLE_SEL_MASK) == GROUP2A_CODE) begin
        function_next[8:5] = instr[3:0];
      end else if ((instr & NIBBLE_SEL_MASK) == GROUP2B_CODE) begin
        function_next[12:9] = instr[3:0];
      end else if (instr == EXPANSION_F13) begin
        if (head.count >= CNT_W'(4)) begin
          function_next[20:13] = arg0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_reg       <= 1'b1;
      function_reg        <= '0;
      previous_final_byte <= '0;
      m_tvalid            <= 1'b0;
    end else begin
      if (pop) begin
        direction_reg       <= direction_next;
        function_reg        <= function_next;
        previous_final_byte <= head.final_byte;
        m_tvalid            <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addressed     <= addressed_next;
      cv_write      <= cv_write_next;
      decoder_reset <= decoder_reset_next;
      cv_number     <= cv_number_next;
      cv_value      <= cv_value_next;
    end
  end

  assign m_tdata = {6'b0, decoder_reset, cv_value, cv_number, cv_write,
                    function_reg, direction_reg, addressed};

endmodule

[rtl/dcc_packet_function_decoder_unit.sv]
// ---------------------------------------------------------------------------
// DCC packet function decoder
// Takes the bytes of DCC packets and reports address match, direction,
// function mask and confirmed CV write or decoder reset requests, one result
// word per packet, issued on the word that carries the last-byte mark.
// ---------------------------------------------------------------------------
// The block takes one packet byte per clock while the queue has room. When its
// last byte is taken, the front end pushes the packet into a two-entry queue;
// the back end pops it once the output register is free and decodes it
// combinationally into that register. The back end sustains one packet per
// clock while the sink does not stall; bytes stall only while the queue is full.
`include "dcc_packet_function_decoder_unit_assert.svh"

module dcc_packet_function_decoder_unit
  import dccfd_pkg::*;
#(
  parameter int MaxBytes = MAX_PACKET_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // packet_byte
  input  logic                   s_tlast,   // last_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // addressed, direction_forward, function_mask[20:0], cv_write,
  // cv_number[8:0], cv_value[7:0], decoder_reset, zero fill
  output logic [TDATA_OUT_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data
);

  logic [ADDR_W-1:0]    own_address;
  logic [CONSIST_W-1:0] consist_address;
  logic [ADDR_W-1:0]    service_address;

  q_status_t q_stat;
  packet_t   push_packet;
  packet_t   head;
  logic      push;
  logic      pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address     <= OWN_ADDRESS_RESET;
      consist_address <= CONSIST_ADDRESS_RESET;
      service_address <= SERVICE_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OWN_ADDRESS:     own_address     <= cfg_data;
        REG_CONSIST_ADDRESS: consist_address <= cfg_data[CONSIST_W-1:0];
        REG_SERVICE_ADDRESS: service_address <= cfg_data;
        default: ;
      endcase
    end
  end

  dccfd_front #(
    .MaxBytes (MaxBytes)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .packet   (push_packet)
  );

  dccfd_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_packet (push_packet),
    .pop         (pop),
    .head        (head),
    .q_stat      (q_stat)
  );

  dccfd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .own_address     (own_address),
    .consist_address (consist_address),
    .service_address (service_address),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

  `DCCFD_ASSERT_IMP(a_no_overflow, push, !q_stat.full, "packet pushed into full queue")
  `DCCFD_ASSERT_NXT(a_valid_source, (!m_tvalid || m_tready) && !pop, !m_tvalid,
                    "result word raised without a queue pop")
  `DCCFD_ASSERT_IMP(a_cv_flags, m_tvalid && (m_tdata[23] || m_tdata[41]),
                    m_tdata[0] && !(m_tdata[23] && m_tdata[41]),
                    "CV request without address match or both requests set")

endmodule

[test/dcc_packet_function_decoder_unit_tb.sv]
// ---------------------------------------------------------------------------
// DCC packet function decoder testbench
// Streams DCC packets byte by byte into the decoder, under random source and
// sink stalls in the first four phases, and checks every packet report
// against a cycle-free model of the address match, direction, F0..F20 mask
// and confirmed CV write logic, over several address register settings.
// ---------------------------------------------------------------------------
module dcc_packet_function_decoder_unit_tb;
  import dccfd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [5:0]        zero_fill;
    logic              decoder_reset;
    logic [7:0]        cv_value;
    logic [8:0]        cv_number;
    logic              cv_write;
    logic [FUNC_W-1:0] function_mask;
    logic              direction_forward;
    logic              addressed;
  } report_t;

  typedef enum int {
    PK_CV, PK_SPEED128, PK_SPEED, PK_GROUP1, PK_GROUP2A, PK_GROUP2B, PK_EXPANSION, PK_NOISE
  } packet_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [ADDR_W-1:0]      cfg_data = '0;

  word_t      pending_words[$];
  report_t    expected_reports[$];
  logic [7:0] packet_body[$];

  logic [ADDR_W-1:0]    own_sh = OWN_ADDRESS_RESET;
  logic [CONSIST_W-1:0] consist_sh = CONSIST_ADDRESS_RESET;
  logic [ADDR_W-1:0]    service_sh = SERVICE_ADDRESS_RESET;

  logic [7:0]        byte_store[MAX_PACKET_BYTES] = '{default: 8'h00};
  int                byte_count = 0;
  logic              dir_sh = 1'b1;
  logic [FUNC_W-1:0] func_sh = '0;
  logic [7:0]        prev_final = 8'h00;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int reports_checked = 0;
  int words_queued = 0;

  dcc_packet_function_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] stored_byte(int pos);
    return (pos < MAX_PACKET_BYTES) ? byte_store[pos] : 8'h00;
  endfunction

  function automatic void decode_packet_byte(logic [7:0] b, logic last);
    int          n, s, dlen;
    logic [7:0]  p0, instr, final_b, cv_b, speed_b;
    logic [13:0] addr;
    report_t     r;
    if (byte_count < MAX_PACKET_BYTES) begin
      byte_store[byte_count] = b;
      byte_count++;
    end
    if (!last) return;
    n = byte_count;
    byte_count = 0;
    dlen = n - 1;
    final_b = stored_byte(n - 1);
    p0 = stored_byte(0);
    s = p0[7];
    addr = s ? {p0[5:0], stored_byte(1)} : {7'd0, p0[6:0]};
    instr = stored_byte(1 + s);
    r = '0;
    if (addr != 0 && (addr == own_sh || addr == service_sh) &&
        (instr & CV_WRITE_MASK) == CV_WRITE_CODE) begin
      r.addressed = 1'b1;
      if (final_b == prev_final) begin
        cv_b = stored_byte(2 + s);
        r.cv_value = stored_byte(3 + s);
        r.cv_number = {1'b0, cv_b} + 9'd1;
        if (cv_b == RESET_CV_BYTE && r.cv_value == RESET_CV_VALUE) r.decoder_reset = 1'b1;
        else r.cv_write = 1'b1;
      end
    end else if (addr != 0 && (addr == own_sh || addr == {7'd0, consist_sh})) begin
      r.addressed = 1'b1;
      if (!instr[7]) begin
        if (instr == SPEED128_CODE && dlen == 3 + s) begin
          speed_b = stored_byte(2 + s);
          dir_sh = speed_b[7];
        end else if (dlen == 2 + s) begin
          dir_sh = instr[5];
        end
      end else if ((instr & GROUP_SEL_MASK) == GROUP1_CODE) begin
        func_sh[0] = instr[4];
        func_sh[4:1] = instr[3:0];
      end else if ((instr & NIBBLE_SEL_MASK) == GROUP2A_CODE) begin
        func_sh[8:5] = instr[3:0];
      end else if ((instr & NIBBLE_SEL_MASK) == GROUP2B_CODE) begin
        func_sh[12:9] = instr[3:0];
      end else if (instr == EXPANSION_F13 && dlen >= 3) begin
        func_sh[20:13] = stored_byte(2 + s);
      end
    end
    prev_final = final_b;
    r.direction_forward = dir_sh;
    r.function_mask = func_sh;
    expected_reports.push_back(r);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : driver
    word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_packet_byte(s_tdata, s_tlast);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          w = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= w.data;
          s_tlast <= w.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    report_t got, want;
    m_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got = report_t'(m_tdata);
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report word %0h", m_tdata);
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        check_field("addressed", want.addressed, got.addressed);
        check_field("direction_forward", want.direction_forward, got.direction_forward);
        check_field("function_mask", want.function_mask, got.function_mask);
        check_field("cv_write", want.cv_write, got.cv_write);
        check_field("cv_number", want.cv_number, got.cv_number);
        check_field("cv_value", want.cv_value, got.cv_value);
        check_field("decoder_reset", want.decoder_reset, got.decoder_reset);
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OWN_ADDRESS:     own_sh = val;
      REG_CONSIST_ADDRESS: consist_sh = val[CONSIST_W-1:0];
      REG_SERVICE_ADDRESS: service_sh = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_packet(bit with_check);
    logic [7:0] chk;
    word_t      w;
    chk = 8'h00;
    foreach (packet_body[i]) begin
      chk ^= packet_body[i];
      w.data = packet_body[i];
      w.last = !with_check && (i == packet_body.size() - 1);
      pending_words.push_back(w);
    end
    words_queued += packet_body.size();
    if (with_check) begin
      w.data = chk;
      w.last = 1'b1;
      pending_words.push_back(w);
      words_queued++;
    end
  endtask

  task automatic put_address(logic [13:0] target);
    if (target < 128 && $urandom_range(1)) begin
      packet_body.push_back({1'b0, target[6:0]});
    end else begin
      packet_body.push_back({1'b1, 1'($urandom_range(1)), target[13:8]});
      packet_body.push_back(target[7:0]);
    end
  endtask

  task automatic queue_random_packet();
    packet_kind_t kind;
    logic [13:0]  target;
    int           pick, repeats;
    bit           with_check;
    pick = $urandom_range(9);
    if (pick < 4) target = own_sh;
    else if (pick < 6) target = {7'd0, consist_sh};
    else if (pick < 8) target = service_sh;
    else if (pick < 9) target = 14'($urandom);
    else target = '0;
    kind = packet_kind_t'($urandom_range(PK_NOISE));
    packet_body.delete();
    with_check = 1'b1;
    if (kind == PK_NOISE) begin
      repeat ($urandom_range(1, 9)) packet_body.push_back(8'($urandom));
      with_check = 1'($urandom_range(1));
    end else begin
      put_address(target);
      case (kind)
        PK_CV: begin
          packet_body.push_back(CV_WRITE_CODE | 8'($urandom_range(3)));
          if ($urandom_range(3) == 0) begin
            packet_body.push_back(RESET_CV_BYTE);
            packet_body.push_back(RESET_CV_VALUE);
          end else begin
            packet_body.push_back(8'($urandom));
            packet_body.push_back(8'($urandom));
          end
        end
        PK_SPEED128: begin
          packet_body.push_back(SPEED128_CODE);
          packet_body.push_back(8'($urandom));
        end
        PK_SPEED:     packet_body.push_back({2'b01, 6'($urandom)});
        PK_GROUP1:    packet_body.push_back({3'b100, 5'($urandom)});
        PK_GROUP2A:   packet_body.push_back({4'b1011, 4'($urandom)});
        PK_GROUP2B:   packet_body.push_back({4'b1010, 4'($urandom)});
        PK_EXPANSION: begin
          packet_body.push_back(EXPANSION_F13);
          packet_body.push_back(8'($urandom));
        end
        default: ;
      endcase
      // bend the length now and then: short packets and overlong ones
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1) && packet_body.size() > 1) void'(packet_body.pop_back());
        else repeat ($urandom_range(1, 4)) packet_body.push_back(8'($urandom));
      end
    end
    repeats = (kind == PK_CV && $urandom_range(9) < 7) ? $urandom_range(1, 2) : 0;
    repeat (repeats + 1) push_packet(with_check);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin idle_pct = 18; stall_pct = 52; end
        1: begin idle_pct = 52; stall_pct = 18; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      case (phase)
        0: begin
          write_reg(REG_OWN_ADDRESS, 14'd3);
          write_reg(REG_CONSIST_ADDRESS, 14'd0);
          write_reg(REG_SERVICE_ADDRESS, 14'd0);
        end
        1: begin
          write_reg(REG_OWN_ADDRESS, 14'd1);
          write_reg(REG_CONSIST_ADDRESS, 14'd127);
          write_reg(REG_SERVICE_ADDRESS, 14'd16383);
        end
        2: begin
          write_reg(REG_OWN_ADDRESS, 14'd10239);
          write_reg(REG_CONSIST_ADDRESS, 14'd1);
          write_reg(REG_SERVICE_ADDRESS, 14'($urandom));
        end
        3: begin
          write_reg(REG_OWN_ADDRESS, 14'd127);
          write_reg(REG_CONSIST_ADDRESS, 14'($urandom_range(127)));
          write_reg(REG_SERVICE_ADDRESS, 14'd128);
        end
        4: begin
          write_reg(REG_OWN_ADDRESS, 14'd128);
          write_reg(REG_CONSIST_ADDRESS, 14'($urandom_range(127)));
          write_reg(REG_SERVICE_ADDRESS, 14'($urandom));
        end
        default: begin
          write_reg(REG_OWN_ADDRESS, 14'($urandom_range(1, 10239)));
          write_reg(REG_CONSIST_ADDRESS, 14'($urandom_range(127)));
          write_reg(REG_SERVICE_ADDRESS, 14'($urandom));
        end
      endcase
      words_queued = 0;
      if (phase == 0) begin
        // overlong packet to zero address: fills every byte slot
        packet_body = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC};
        push_packet(1'b0);
        // lone byte packet with a long address
        packet_body = '{8'hFF};
        push_packet(1'b0);
        // decoder reset, sent twice to confirm
        packet_body = '{8'h03, CV_WRITE_CODE, RESET_CV_BYTE, RESET_CV_VALUE};
        push_packet(1'b1);
        push_packet(1'b1);
        packet_body = '{8'h03, SPEED128_CODE, 8'h05};
        push_packet(1'b1);
      end
      while (words_queued < 122) queue_random_packet();
      wait_drained();
    end
    $display("Covered %0d packet bytes and %0d packet reports over 6 address settings",
             bytes_sent, reports_checked);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2400000;
    $display("timeout with %0d reports outstanding", expected_reports.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
